// ----- hw/rtl/isj_pkg.sv -----
// ----------------------------------------------------------------------------
// isj_pkg
// Shared constants and types for the synchronised joint speed block.
// ----------------------------------------------------------------------------
package isj_pkg;

    localparam int JOINTS_DEF = 6;   // default number of joints in a set
    localparam int REGS       = 6;   // reference speed registers on the APB port
    localparam int DATA_W     = 32;  // Q16.16 word
    localparam int FRAC_W     = 16;  // fraction bits
    localparam int JNUM_W     = 3;   // joint index width
    localparam int ADDR_W     = 5;   // byte address of REGS 32-bit registers
    localparam int STEP_W     = 5;   // divider step counter, one quotient bit a step

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_EMIT_START,
        ST_EMIT_DIV,
        ST_EMIT_PUT
    } isj_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } isj_div_stat_t;

endpackage

// ----- hw/rtl/isj_div.sv -----
// ----------------------------------------------------------------------------
// isj_div
// Iterative Q16.16 divider: floor(num * 2^16 / den), saturating, zero on den 0.
// ----------------------------------------------------------------------------
module isj_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [isj_pkg::DATA_W-1:0]    num,
    input  logic [isj_pkg::DATA_W-1:0]    den,
    output isj_pkg::isj_div_stat_t        stat,
    output logic [isj_pkg::DATA_W-1:0]    quo
);

    localparam int W  = isj_pkg::DATA_W;
    localparam int F  = isj_pkg::FRAC_W;
    localparam int SW = isj_pkg::STEP_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(W - 1);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  qs_reg;

    logic          den_zero;
    logic          sat;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    // quotient fits 32 bits only when num < den * 2^16
    assign den_zero = (den == '0);
    assign sat      = ({{F{1'b0}}, num} >= {den, {F{1'b0}}});

    assign trial = {rem_reg, qs_reg[W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= !(den_zero || sat);
            done_reg <= den_zero || sat;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (den_zero)
            begin
                qs_reg <= '0;
            end
            else if (sat)
            begin
                qs_reg <= '1;
            end
            else
            begin
                rem_reg <= {{(W-F){1'b0}}, num[W-1:F]};
                qs_reg  <= {num[F-1:0], {(W-F){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, one quotient bit out
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            qs_reg  <= {qs_reg[W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = qs_reg;

endmodule

// ----- hw/rtl/isochronous_joint_speeds.sv -----
// ----------------------------------------------------------------------------
// isochronous_joint_speeds
// Scales joint speeds so that every joint of a set ends its move together.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               beat contents
//  in       sink       in_valid / in_stall     joint_position, joint_target, last_joint
//  out      source     out_valid / out_stall   joint_speed, joint_number, move_duration,
//                                              will_move, last_result
//  apb      slave      psel/penable/pwrite     ref_speed_0..5 at byte address 4*i
//
//  A skipped joint is taken in the idle state alone; any other input beat
//  waits in the time state on the shared divider, which resolves one quotient
//  bit a cycle over 32 steps, and skips the steps when the travel time saturates.
//  The closing beat of a set then gives one result beat per loaded joint, each
//  a further pass through the same divider (no steps when the quotient
//  saturates or the largest time is zero), and waits while the output is stalled.
//  Reset clears the sequencer, joint counter, largest time and reference speeds;
//  the distance store holds nothing meaningful until written.
//  in_stall is high whenever the sequencer is busy; out_stall holds the result
//  register and the sequencer until the beat is taken.
// ----------------------------------------------------------------------------
module isochronous_joint_speeds #(
    parameter int JOINTS = isj_pkg::JOINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [isj_pkg::DATA_W-1:0] joint_position,
    input  logic signed [isj_pkg::DATA_W-1:0] joint_target,
    input  logic                           last_joint,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [isj_pkg::DATA_W-1:0]     joint_speed,
    output logic [isj_pkg::JNUM_W-1:0]     joint_number,
    output logic [isj_pkg::DATA_W-1:0]     move_duration,
    output logic                           will_move,
    output logic                           last_result,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [isj_pkg::ADDR_W-1:0]     paddr,
    input  logic [isj_pkg::DATA_W-1:0]     pwdata,
    output logic [isj_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int W  = isj_pkg::DATA_W;
    localparam int JW = isj_pkg::JNUM_W;
    localparam logic [JW-1:0] LAST_J  = JW'(JOINTS - 1);
    localparam logic [JW-1:0] REG_CNT = JW'(isj_pkg::REGS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    isj_pkg::isj_state_t state_reg, state_next;

    logic [W-1:0]  ref_speed_reg [isj_pkg::REGS];
    logic [W-1:0]  dist_mem      [JOINTS];
    logic [W-1:0]  largest_reg;
    logic [JW-1:0] jc_reg;
    logic [JW-1:0] k_reg;
    logic [JW-1:0] cnt_reg;
    logic          end_reg;

    logic          out_valid_reg;
    logic [W-1:0]  joint_speed_reg;
    logic [JW-1:0] joint_number_reg;
    logic [W-1:0]  move_duration_reg;
    logic          will_move_reg;
    logic          last_result_reg;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic [JW-1:0] j_cur;
    logic [W-1:0]  spd_cur;
    logic          skip;
    logic [W:0]    diff;
    logic [W:0]    mag;
    logic [W-1:0]  dist_cur;
    logic          end_in;
    logic          in_acc;
    logic          out_free;
    logic          last_k;
    logic          cfg_wr;
    logic [JW-1:0] cfg_idx;

    logic          div_start;
    logic [W-1:0]  div_num;
    logic [W-1:0]  div_den;
    logic [W-1:0]  div_quo;
    isj_pkg::isj_div_stat_t div_stat;

    assign j_cur    = (jc_reg > LAST_J) ? '0 : jc_reg;
    assign spd_cur  = ref_speed_reg[j_cur];
    // zero or negative reference speed drops the joint from the move
    assign skip     = (spd_cur == '0) || spd_cur[W-1];
    assign diff     = {joint_target[W-1], joint_target} - {joint_position[W-1], joint_position};
    assign mag      = diff[W] ? (~diff + 1'b1) : diff;
    assign dist_cur = skip ? '0 : mag[W-1:0];
    // a set closes on the end mark or on its final joint
    assign end_in   = last_joint || (j_cur == LAST_J);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign last_k   = (k_reg == cnt_reg);

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[isj_pkg::ADDR_W-1:2];

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    isj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isj_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!skip)
                    begin
                        state_next = isj_pkg::ST_TIME;
                    end
                    else if (end_in)
                    begin
                        state_next = isj_pkg::ST_EMIT_START;
                    end
                end
            end
            isj_pkg::ST_TIME:
            begin
                if (div_stat.done)
                begin
                    state_next = end_reg ? isj_pkg::ST_EMIT_START : isj_pkg::ST_IDLE;
                end
            end
            isj_pkg::ST_EMIT_START:
            begin
                state_next = isj_pkg::ST_EMIT_DIV;
            end
            isj_pkg::ST_EMIT_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = isj_pkg::ST_EMIT_PUT;
                end
            end
            isj_pkg::ST_EMIT_PUT:
            begin
                if (out_free)
                begin
                    state_next = last_k ? isj_pkg::ST_IDLE : isj_pkg::ST_EMIT_START;
                end
            end
            default:
            begin
                state_next = isj_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        div_num   = dist_mem[k_reg];
        div_den   = largest_reg;
        unique case (state_reg)
            isj_pkg::ST_IDLE:
            begin
                // travel time of this joint: distance over reference speed
                in_stall  = 1'b0;
                div_start = in_acc && !skip;
                div_num   = dist_cur;
                div_den   = spd_cur;
            end
            isj_pkg::ST_EMIT_START:
            begin
                // synchronised speed: stored distance over the largest time
                div_start = 1'b1;
            end
            isj_pkg::ST_TIME,
            isj_pkg::ST_EMIT_DIV,
            isj_pkg::ST_EMIT_PUT:
            begin
                div_start = 1'b0;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isj_pkg::ST_IDLE;
            jc_reg        <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < isj_pkg::REGS; i++)
            begin
                ref_speed_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr && (cfg_idx < REG_CNT))
            begin
                ref_speed_reg[cfg_idx] <= pwdata;
            end

            // load a joint: advance the counter or close the set
            if (in_acc)
            begin
                end_reg <= end_in;
                cnt_reg <= j_cur;
                k_reg   <= '0;
                jc_reg  <= end_in ? '0 : (j_cur + 1'b1);
            end

            // keep the largest travel time
            if ((state_reg == isj_pkg::ST_TIME) && div_stat.done && (div_quo > largest_reg))
            begin
                largest_reg <= div_quo;
            end

            if ((state_reg == isj_pkg::ST_EMIT_PUT) && out_free)
            begin
                if (last_k)
                begin
                    largest_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end

            // result register: set on load, drop once the beat is taken
            if ((state_reg == isj_pkg::ST_EMIT_PUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and distance store
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dist_mem[j_cur] <= dist_cur;
        end
        if ((state_reg == isj_pkg::ST_EMIT_PUT) && out_free)
        begin
            joint_speed_reg   <= div_quo;
            joint_number_reg  <= k_reg;
            move_duration_reg <= largest_reg;
            will_move_reg     <= (largest_reg != '0);
            last_result_reg   <= last_k;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign out_valid     = out_valid_reg;
    assign joint_speed   = joint_speed_reg;
    assign joint_number  = joint_number_reg;
    assign move_duration = move_duration_reg;
    assign will_move     = will_move_reg;
    assign last_result   = last_result_reg;

    assign pready = 1'b1;
    assign prdata = (cfg_idx < REG_CNT) ? ref_speed_reg[cfg_idx] : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_jc_range: assert property (@(posedge clk) disable iff (!rst_n)
        jc_reg <= LAST_J)
        else $error("joint counter out of range");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isj_pkg::ST_EMIT_PUT) |-> (k_reg <= cnt_reg))
        else $error("result index beyond loaded joints");

    a_will_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (will_move == (move_duration != '0)))
        else $error("will_move disagrees with move_duration");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == isj_pkg::ST_EMIT_PUT) && out_free && last_k)
        |=> ((largest_reg == '0) && (state_reg == isj_pkg::ST_IDLE) && last_result))
        else $error("set did not close cleanly");

endmodule
